>>> rtl/sxbt_pkg.sv
package sxbt_pkg;

    localparam int ADDRESS_COUNT = 112;
    localparam int IDX_W         = 7;
    localparam int FRAME_BYTES   = 7;
    localparam int BYTE_TICKS    = 12;
    localparam int FRAME_TICKS   = 6;
    localparam int SEP_LEN       = 3;

    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic [2:0] {
        CMD_TICK       = 3'd0,
        CMD_READ       = 3'd1,
        CMD_WRITE      = 3'd2,
        CMD_POWER      = 3'd3,
        CMD_SYNC_QUERY = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        DRV_LOW     = 2'd0,
        DRV_HIGH    = 2'd1,
        DRV_RELEASE = 2'd2,
        DRV_HOLD    = 2'd3
    } drive_t;

    // power request register: 0 or 1 = bit to drive, PREQ_NONE = nothing pending
    localparam logic [1:0] PREQ_NONE = 2'd2;

    typedef struct packed {
        cmd_t       command;
        logic       bus_bit;
        logic [7:0] address;
        logic [7:0] write_value;
        logic       power_value;
        idx_t       slot;
    } item_t;

    typedef struct packed {
        drive_t     drive;
        logic [7:0] read_value;
        logic       address_error;
        logic       power_status;
        logic       sync_seen;
    } result_t;

    typedef struct packed {
        logic       en;
        idx_t       idx;
        logic [7:0] data;
        logic       pend;
    } mem_wr_t;

    typedef struct packed {
        logic en;
        idx_t idx;
    } idx_req_t;

    function automatic logic addr_ok(logic [7:0] addr);
        return addr < 8'(ADDRESS_COUNT);
    endfunction

    function automatic logic idx_ok(idx_t i);
        return i < IDX_W'(ADDRESS_COUNT);
    endfunction

    // store order: frame 15 first, highest byte of a frame first
    function automatic idx_t slot_of(logic [7:0] addr);
        logic [3:0] fr;
        logic [2:0] off;
        fr  = 4'd15 - addr[3:0];
        off = 3'd6 - addr[6:4];
        return idx_t'({fr, 3'b000}) - idx_t'(fr) + idx_t'(off);
    endfunction

endpackage

>>> rtl/sxbt_mirror.sv
module sxbt_mirror (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sxbt_pkg::mem_wr_t    wr,
    input  sxbt_pkg::idx_req_t   clr,
    input  sxbt_pkg::idx_req_t   rd_a,
    input  sxbt_pkg::idx_req_t   rd_b,
    input  sxbt_pkg::idx_t       host_idx,
    input  sxbt_pkg::idx_t       cur_idx,
    input  sxbt_pkg::idx_t       next_idx,
    output logic                 host_valid,
    output logic                 cur_pending,
    output logic                 next_pending,
    output logic [7:0]           rdata_a,
    output logic [7:0]           rdata_b
);

    logic [7:0] mem [sxbt_pkg::ADDRESS_COUNT];
    logic [7:0] rdata_a_reg;
    logic [7:0] rdata_b_reg;
    logic [sxbt_pkg::ADDRESS_COUNT-1:0] valid_reg;
    logic [sxbt_pkg::ADDRESS_COUNT-1:0] pending_reg;

    // byte array, write-first forwarding on both read ports
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.idx] <= wr.data;
        end
        if (rd_a.en) begin
            rdata_a_reg <= (wr.en && wr.idx == rd_a.idx) ? wr.data : mem[rd_a.idx];
        end
        if (rd_b.en) begin
            rdata_b_reg <= (wr.en && wr.idx == rd_b.idx) ? wr.data : mem[rd_b.idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            pending_reg <= '0;
        end else begin
            if (wr.en) begin
                valid_reg[wr.idx]   <= 1'b1;
                pending_reg[wr.idx] <= wr.pend;
            end
            if (clr.en) begin
                pending_reg[clr.idx] <= 1'b0;
            end
        end
    end

    assign host_valid   = sxbt_pkg::idx_ok(host_idx) && valid_reg[host_idx];
    assign cur_pending  = sxbt_pkg::idx_ok(cur_idx)  && pending_reg[cur_idx];
    assign next_pending = sxbt_pkg::idx_ok(next_idx) && pending_reg[next_idx];
    assign rdata_a      = rdata_a_reg;
    assign rdata_b      = rdata_b_reg;

endmodule

>>> rtl/sxbt_engine.sv
module sxbt_engine #(
    parameter int SYNC_ZEROS = 3
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 proc,
    input  sxbt_pkg::item_t      item,
    input  logic                 host_valid,
    input  logic                 cur_pending,
    input  logic                 next_pending,
    input  logic [7:0]           rdata_a,
    input  logic [7:0]           rdata_b,
    output sxbt_pkg::mem_wr_t    wr,
    output sxbt_pkg::idx_req_t   clr,
    output sxbt_pkg::idx_req_t   rd_b,
    output sxbt_pkg::idx_t       cur_idx,
    output sxbt_pkg::idx_t       next_idx,
    output sxbt_pkg::result_t    res
);

    localparam logic [3:0] SYNC_LOAD = 4'(SYNC_ZEROS);

    typedef enum logic [3:0] {
        PH_SYNC  = 4'b0001,
        PH_POWER = 4'b0010,
        PH_FRAME = 4'b0100,
        PH_DATA  = 4'b1000
    } phase_t;

    phase_t         phase_reg, phase_next;
    logic [1:0]     sep_reg, sep_next;
    logic [3:0]     bit_count_reg, bit_count_next;
    logic [2:0]     bytes_left_reg, bytes_left_next;
    logic [3:0]     frame_reg, frame_next;
    sxbt_pkg::idx_t store_index_reg, store_index_next;
    logic           sending_reg, sending_next;
    logic [7:0]     send_shift_reg, send_shift_next;
    logic           send_fresh_reg, send_fresh_next;
    logic [7:0]     receive_shift_reg, receive_shift_next;
    logic           power_seen_reg, power_seen_next;
    logic           frame_zero_reg, frame_zero_next;
    logic [1:0]     power_req_reg, power_req_next;

    logic [1:0]     sep_dec;
    logic [3:0]     cnt_dec;
    logic [2:0]     bytes_dec;
    logic [3:0]     frame_new;
    logic [7:0]     send_cur;
    logic [7:0]     receive_new;
    sxbt_pkg::idx_t prep_idx;
    logic           do_prep;

    assign sep_dec   = sep_reg - 2'd1;
    assign cnt_dec   = bit_count_reg - 4'd1;
    assign bytes_dec = bytes_left_reg - 3'd1;
    assign frame_new = (sep_dec == 2'd0) ? frame_reg : {frame_reg[2:0], item.bus_bit};
    assign receive_new = {item.bus_bit, receive_shift_reg[7:1]};
    // a freshly loaded send byte arrives from the store in the cycle after prepare
    assign send_cur  = send_fresh_reg ? rdata_b : send_shift_reg;
    assign prep_idx  = (phase_reg == PH_FRAME)
                     ? sxbt_pkg::idx_t'({frame_new, 3'b000}) - sxbt_pkg::idx_t'(frame_new)
                     : store_index_reg + sxbt_pkg::idx_t'(1);
    assign cur_idx   = store_index_reg;
    assign next_idx  = prep_idx;

    always_comb begin
        phase_next         = phase_reg;
        sep_next           = sep_reg;
        bit_count_next     = bit_count_reg;
        bytes_left_next    = bytes_left_reg;
        frame_next         = frame_reg;
        store_index_next   = store_index_reg;
        sending_next       = sending_reg;
        send_shift_next    = send_shift_reg;
        send_fresh_next    = send_fresh_reg;
        receive_shift_next = receive_shift_reg;
        power_seen_next    = power_seen_reg;
        frame_zero_next    = frame_zero_reg;
        power_req_next     = power_req_reg;
        do_prep            = 1'b0;
        wr                 = '0;
        clr                = '0;
        rd_b               = '0;
        res.drive          = sxbt_pkg::DRV_HOLD;
        res.read_value     = 8'd0;
        res.address_error  = 1'b0;

        if (proc) begin
            if (send_fresh_reg) begin
                send_shift_next = rdata_b;
                send_fresh_next = 1'b0;
            end
            unique case (item.command)
                sxbt_pkg::CMD_TICK: begin
                    unique case (phase_reg)
                        PH_SYNC: begin
                            if (!item.bus_bit) begin
                                if (bit_count_reg != 4'd0) begin
                                    bit_count_next = cnt_dec;
                                end
                            end else if (bit_count_reg == 4'd0) begin
                                phase_next = PH_POWER;
                                sep_next   = 2'(sxbt_pkg::SEP_LEN - 1);
                            end else begin
                                bit_count_next = SYNC_LOAD;
                                sending_next   = 1'b0;
                            end
                        end
                        PH_POWER: begin
                            sep_next = sep_dec;
                            if (sep_dec == 2'd0) begin
                                res.drive      = sxbt_pkg::DRV_RELEASE;
                                phase_next     = PH_FRAME;
                                bit_count_next = 4'(sxbt_pkg::FRAME_TICKS);
                                sep_next       = 2'(sxbt_pkg::SEP_LEN);
                                frame_next     = 4'd0;
                            end else begin
                                if (power_req_reg != sxbt_pkg::PREQ_NONE) begin
                                    res.drive = power_req_reg[0] ? sxbt_pkg::DRV_HIGH
                                                                 : sxbt_pkg::DRV_LOW;
                                    power_req_next = sxbt_pkg::PREQ_NONE;
                                end
                                power_seen_next = item.bus_bit;
                            end
                        end
                        PH_FRAME: begin
                            sep_next = (sep_dec == 2'd0) ? 2'(sxbt_pkg::SEP_LEN) : sep_dec;
                            frame_next     = frame_new;
                            bit_count_next = cnt_dec;
                            if (cnt_dec == 4'd0) begin
                                if (frame_new == 4'd0) begin
                                    frame_zero_next = 1'b1;
                                end
                                phase_next     = PH_DATA;
                                bit_count_next = 4'(sxbt_pkg::BYTE_TICKS);
                                do_prep        = 1'b1;
                            end
                        end
                        PH_DATA: begin
                            sep_next = sep_dec;
                            if (sep_dec == 2'd0) begin
                                res.drive = sxbt_pkg::DRV_RELEASE;
                                sep_next  = 2'(sxbt_pkg::SEP_LEN);
                            end else if (sending_reg) begin
                                res.drive = send_cur[0] ? sxbt_pkg::DRV_HIGH
                                                        : sxbt_pkg::DRV_LOW;
                                send_shift_next = {1'b0, send_cur[7:1]};
                            end else begin
                                receive_shift_next = receive_new;
                            end
                            bit_count_next = cnt_dec;
                            if (cnt_dec == 4'd0) begin
                                // keep a host write that arrived during the byte
                                if (!sending_reg && sxbt_pkg::idx_ok(store_index_reg)
                                        && !cur_pending) begin
                                    wr.en   = 1'b1;
                                    wr.idx  = store_index_reg;
                                    wr.data = receive_shift_next;
                                    wr.pend = 1'b0;
                                end
                                bit_count_next   = 4'(sxbt_pkg::BYTE_TICKS);
                                store_index_next = prep_idx;
                                bytes_left_next  = bytes_dec;
                                if (bytes_dec == 3'd0) begin
                                    bytes_left_next = 3'(sxbt_pkg::FRAME_BYTES);
                                    phase_next      = PH_SYNC;
                                    bit_count_next  = SYNC_LOAD;
                                    sending_next    = 1'b0;
                                end else begin
                                    do_prep = 1'b1;
                                end
                            end
                        end
                        default: begin
                            phase_next = PH_SYNC;
                        end
                    endcase
                end
                sxbt_pkg::CMD_READ: begin
                    if (sxbt_pkg::addr_ok(item.address)) begin
                        res.read_value = host_valid ? rdata_a : 8'd0;
                    end else begin
                        res.address_error = 1'b1;
                    end
                end
                sxbt_pkg::CMD_WRITE: begin
                    if (sxbt_pkg::addr_ok(item.address)) begin
                        wr.en   = 1'b1;
                        wr.idx  = item.slot;
                        wr.data = item.write_value;
                        wr.pend = 1'b1;
                    end else begin
                        res.address_error = 1'b1;
                    end
                end
                sxbt_pkg::CMD_POWER: begin
                    power_req_next = {1'b0, item.power_value};
                end
                sxbt_pkg::CMD_SYNC_QUERY: begin
                    frame_zero_next = 1'b0;
                end
                default: begin
                end
            endcase

            // load the next byte to send if the host left one pending
            if (do_prep) begin
                store_index_next = prep_idx;
                sending_next     = 1'b0;
                if (sxbt_pkg::idx_ok(prep_idx) && next_pending) begin
                    clr.en          = 1'b1;
                    clr.idx         = prep_idx;
                    rd_b.en         = 1'b1;
                    rd_b.idx        = prep_idx;
                    sending_next    = 1'b1;
                    send_fresh_next = 1'b1;
                end
            end
        end

        res.power_status = power_seen_next;
        res.sync_seen    = (item.command == sxbt_pkg::CMD_SYNC_QUERY) ? frame_zero_reg
                                                                      : frame_zero_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_SYNC;
            sep_reg           <= 2'(sxbt_pkg::SEP_LEN);
            bit_count_reg     <= SYNC_LOAD;
            bytes_left_reg    <= 3'(sxbt_pkg::FRAME_BYTES);
            frame_reg         <= 4'd0;
            store_index_reg   <= '0;
            sending_reg       <= 1'b0;
            send_shift_reg    <= 8'd0;
            send_fresh_reg    <= 1'b0;
            receive_shift_reg <= 8'd0;
            power_seen_reg    <= 1'b0;
            frame_zero_reg    <= 1'b0;
            power_req_reg     <= sxbt_pkg::PREQ_NONE;
        end else begin
            phase_reg         <= phase_next;
            sep_reg           <= sep_next;
            bit_count_reg     <= bit_count_next;
            bytes_left_reg    <= bytes_left_next;
            frame_reg         <= frame_next;
            store_index_reg   <= store_index_next;
            sending_reg       <= sending_next;
            send_shift_reg    <= send_shift_next;
            send_fresh_reg    <= send_fresh_next;
            receive_shift_reg <= receive_shift_next;
            power_seen_reg    <= power_seen_next;
            frame_zero_reg    <= frame_zero_next;
            power_req_reg     <= power_req_next;
        end
    end

endmodule

>>> rtl/selectrix_bus_frame_transceiver.sv
// Selectrix bus frame transceiver. Each request carries one command: a bus
// tick with the sampled data line level, a host read or write of one of the
// 112 bus addresses, a power bit request, or a query that returns and clears
// the "frame 0 passed" flag. Each request yields exactly one response with the
// pin action for a bus tick (low, high, release or unchanged), the read byte,
// an address error flag, the last power bit seen and the sync flag. The block
// takes one request per clock while the response channel is not stalled; an
// accepted request is loaded into the input register, and its response into
// the response register once that is free or being emptied. The throughput of
// one request per cycle is set by the single pass through the frame decoder
// between those two registers, with host reads launched into the byte store
// at accept time. The byte store keeps 112 bytes in a memory plus per-entry
// valid and pending flags in flops; reset clears the flags at once, so there
// is no clearing pass and requests are taken right after reset. Host writes
// are sent on the bus on the next pass of their frame and take precedence
// over bytes read from the bus.
module selectrix_bus_frame_transceiver #(
    parameter int SYNC_ZEROS = 3
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] bus_bit, [8:1] address, [16:9] write_value, [17] power_value
    input  logic [23:0] s_tdata,
    // [2:0] command
    input  logic [2:0]  s_tuser,
    // response channel
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] drive, [9:2] read_value, [10] address_error, [11] power_status,
    // [12] sync_seen
    output logic [15:0] m_tdata
);

    logic              in_valid_reg, in_valid_next;
    sxbt_pkg::item_t   item_reg;
    sxbt_pkg::item_t   item_in;
    logic              out_valid_reg, out_valid_next;
    sxbt_pkg::result_t result_reg;
    sxbt_pkg::result_t result_comb;

    logic advance;
    logic proc;
    logic accept;

    sxbt_pkg::mem_wr_t  wr;
    sxbt_pkg::idx_req_t clr;
    sxbt_pkg::idx_req_t rd_a;
    sxbt_pkg::idx_req_t rd_b;
    sxbt_pkg::idx_t     cur_idx;
    sxbt_pkg::idx_t     next_idx;
    logic               host_valid;
    logic               cur_pending;
    logic               next_pending;
    logic [7:0]         rdata_a;
    logic [7:0]         rdata_b;

    // unpack the request and map the bus address to its store entry
    always_comb begin
        item_in.command     = sxbt_pkg::cmd_t'(s_tuser);
        item_in.bus_bit     = s_tdata[0];
        item_in.address     = s_tdata[8:1];
        item_in.write_value = s_tdata[16:9];
        item_in.power_value = s_tdata[17];
        item_in.slot        = sxbt_pkg::slot_of(s_tdata[8:1]);
    end

    // advance whenever the response register is free or being emptied
    assign advance  = !out_valid_reg || m_tready;
    assign proc     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    // launch the host read at accept; the byte is ready when the request is decoded
    assign rd_a.en  = accept;
    assign rd_a.idx = item_in.slot;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (proc) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (proc) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers: hold while stalled
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_in;
        end
        if (proc) begin
            result_reg <= result_comb;
        end
    end

    sxbt_engine #(
        .SYNC_ZEROS (SYNC_ZEROS)
    ) u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .proc         (proc),
        .item         (item_reg),
        .host_valid   (host_valid),
        .cur_pending  (cur_pending),
        .next_pending (next_pending),
        .rdata_a      (rdata_a),
        .rdata_b      (rdata_b),
        .wr           (wr),
        .clr          (clr),
        .rd_b         (rd_b),
        .cur_idx      (cur_idx),
        .next_idx     (next_idx),
        .res          (result_comb)
    );

    sxbt_mirror u_mirror (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .wr           (wr),
        .clr          (clr),
        .rd_a         (rd_a),
        .rd_b         (rd_b),
        .host_idx     (item_reg.slot),
        .cur_idx      (cur_idx),
        .next_idx     (next_idx),
        .host_valid   (host_valid),
        .cur_pending  (cur_pending),
        .next_pending (next_pending),
        .rdata_a      (rdata_a),
        .rdata_b      (rdata_b)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       result_reg.sync_seen,
                       result_reg.power_status,
                       result_reg.address_error,
                       result_reg.read_value,
                       result_reg.drive};

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;

    import sxbt_pkg::*;

    localparam int SYNC_ZEROS  = 3;
    localparam int ITEM_TARGET = 1550;
    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_MAX  = 10;
    localparam int IDLE_PCT    = 36;
    localparam int DRAIN_TAIL  = 16;

    // pressure points, counted in accepted requests
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int PAUSE_AT     = 700;
    localparam int STEADY_FROM  = 900;
    localparam int STEADY_TO    = 1150;

    // mirror entry: bit 8 marks a host write still waiting to go out on the bus
    localparam int MIRROR_PEND = 8;
    localparam int LAST_FRAME  = 15;

    // command codes the block ignores
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

    localparam result_t NO_EFFECT  = '{DRV_HOLD, 8'h00, 1'b0, 1'b0, 1'b0};
    localparam result_t ADDR_FAULT = '{DRV_HOLD, 8'h00, 1'b1, 1'b0, 1'b0};

    typedef enum logic [1:0] {
        SX_SEARCH,
        SX_POWER,
        SX_FRAME,
        SX_DATA
    } sx_phase_t;

    typedef struct {
        logic [2:0] cmd;
        logic       b;
        logic [7:0] a;
        logic [7:0] wv;
        logic       pv;
        bit         typed;
        result_t    want;
    } dir_row_t;

    localparam int DIR_ROWS = 23;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    dir_row_t dir_tab [DIR_ROWS];
    result_t  resp_q [$];
    int       n_sent = 0;
    int       n_acc  = 0;
    int       n_resp = 0;
    int       n_err  = 0;

    // bus decoder copy: telegram position, shift registers and the byte mirror
    sx_phase_t  sx_phase;
    logic [1:0] sx_sep;
    logic [3:0] sx_bits;
    logic [2:0] sx_bytes_left;
    logic [3:0] sx_frame;
    logic [6:0] sx_idx;
    logic       sx_sending;
    logic [7:0] sx_tx_sr;
    logic [7:0] sx_rx_sr;
    logic       sx_power_seen;
    logic       sx_frame0;
    logic [1:0] sx_power_req;
    logic [8:0] sx_mirror [ADDRESS_COUNT];

    selectrix_bus_frame_transceiver #(
        .SYNC_ZEROS(SYNC_ZEROS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Bus decoder prediction
    // ------------------------------------------------------------------

    task automatic sx_reset();
        sx_phase      = SX_SEARCH;
        sx_sep        = 2'(SEP_LEN);
        sx_bits       = 4'(SYNC_ZEROS);
        sx_bytes_left = 3'(FRAME_BYTES);
        sx_frame      = '0;
        sx_idx        = '0;
        sx_sending    = 1'b0;
        sx_tx_sr      = '0;
        sx_rx_sr      = '0;
        sx_power_seen = 1'b0;
        sx_frame0     = 1'b0;
        sx_power_req  = PREQ_NONE;
        for (int i = 0; i < ADDRESS_COUNT; i++) sx_mirror[i] = '0;
    endtask

    // bus address to mirror entry: frame 15 first, highest byte of a frame first
    function automatic int mirror_slot(logic [7:0] a);
        return (LAST_FRAME - int'(a[3:0])) * FRAME_BYTES + (FRAME_BYTES - 1 - int'(a[6:4]));
    endfunction

    // take a pending host byte for the current entry, if there is one
    task automatic sx_load_byte();
        sx_sending = 1'b0;
        if (sx_idx < ADDRESS_COUNT && sx_mirror[sx_idx][MIRROR_PEND]) begin
            sx_mirror[sx_idx][MIRROR_PEND] = 1'b0;
            sx_tx_sr   = sx_mirror[sx_idx][7:0];
            sx_sending = 1'b1;
        end
    endtask

    task automatic sx_tick(input logic b, output drive_t drv);
        drv = DRV_HOLD;
        case (sx_phase)
            SX_SEARCH: begin
                if (!b) begin
                    // saturate the zero count
                    if (sx_bits != 4'd0) sx_bits = sx_bits - 4'd1;
                end else if (sx_bits == 4'd0) begin
                    sx_phase = SX_POWER;
                    sx_sep   = 2'(SEP_LEN - 1);
                end else begin
                    // one came too early: restart the zero count
                    sx_bits    = 4'(SYNC_ZEROS);
                    sx_sending = 1'b0;
                end
            end
            SX_POWER: begin
                sx_sep = sx_sep - 2'd1;
                if (sx_sep == 2'd0) begin
                    drv      = DRV_RELEASE;
                    sx_phase = SX_FRAME;
                    sx_bits  = 4'(FRAME_TICKS);
                    sx_sep   = 2'(SEP_LEN);
                    sx_frame = '0;
                end else begin
                    if (sx_power_req != PREQ_NONE) begin
                        drv          = drive_t'(sx_power_req);
                        sx_power_req = PREQ_NONE;
                    end
                    sx_power_seen = b;
                end
            end
            SX_FRAME: begin
                sx_sep = sx_sep - 2'd1;
                if (sx_sep == 2'd0) sx_sep = 2'(SEP_LEN);
                else sx_frame = {sx_frame[2:0], b};
                sx_bits = sx_bits - 4'd1;
                if (sx_bits == 4'd0) begin
                    if (sx_frame == 4'd0) sx_frame0 = 1'b1;
                    sx_phase = SX_DATA;
                    sx_bits  = 4'(BYTE_TICKS);
                    sx_idx   = 7'(int'(sx_frame) * FRAME_BYTES);
                    sx_load_byte();
                end
            end
            default: begin
                sx_sep = sx_sep - 2'd1;
                if (sx_sep == 2'd0) begin
                    drv    = DRV_RELEASE;
                    sx_sep = 2'(SEP_LEN);
                end else if (sx_sending) begin
                    drv      = sx_tx_sr[0] ? DRV_HIGH : DRV_LOW;
                    sx_tx_sr = sx_tx_sr >> 1;
                end else begin
                    sx_rx_sr = {b, sx_rx_sr[7:1]};
                end
                sx_bits = sx_bits - 4'd1;
                if (sx_bits == 4'd0) begin
                    // a host write that landed mid-byte wins over the byte read
                    if (!sx_sending && sx_idx < ADDRESS_COUNT && !sx_mirror[sx_idx][MIRROR_PEND])
                        sx_mirror[sx_idx] = {1'b0, sx_rx_sr};
                    sx_bits       = 4'(BYTE_TICKS);
                    sx_idx        = sx_idx + 7'd1;
                    sx_bytes_left = sx_bytes_left - 3'd1;
                    if (sx_bytes_left == 3'd0) begin
                        sx_bytes_left = 3'(FRAME_BYTES);
                        sx_phase      = SX_SEARCH;
                        sx_bits       = 4'(SYNC_ZEROS);
                        sx_sending    = 1'b0;
                    end else begin
                        sx_load_byte();
                    end
                end
            end
        endcase
    endtask

    task automatic sx_step(input logic [2:0] cmd, input logic b, input logic [7:0] a,
                           input logic [7:0] wv, input logic pv, output result_t r);
        drive_t drv;
        r = NO_EFFECT;
        case (cmd)
            CMD_TICK: begin
                sx_tick(b, drv);
                r.drive = drv;
            end
            CMD_READ: begin
                if (a < ADDRESS_COUNT) r.read_value = sx_mirror[mirror_slot(a)][7:0];
                else r.address_error = 1'b1;
            end
            CMD_WRITE: begin
                if (a < ADDRESS_COUNT) sx_mirror[mirror_slot(a)] = {1'b1, wv};
                else r.address_error = 1'b1;
            end
            CMD_POWER: sx_power_req = {1'b0, pv};
            default: ;
        endcase
        r.power_status = sx_power_seen;
        // query returns the flag as it was, then clears it
        r.sync_seen = sx_frame0;
        if (cmd == CMD_SYNC_QUERY) sx_frame0 = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Scoreboard: check responses first, then predict the accepted request
    // ------------------------------------------------------------------

    always @(posedge aclk) begin : scoreboard
        result_t got;
        result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.drive         = drive_t'(m_tdata[1:0]);
                got.read_value    = m_tdata[9:2];
                got.address_error = m_tdata[10];
                got.power_status  = m_tdata[11];
                got.sync_seen     = m_tdata[12];
                if (resp_q.size() == 0) begin
                    if (n_err < REPORT_MAX)
                        $display("response %0d arrived with no request outstanding: %h",
                                 n_resp, m_tdata);
                    n_err++;
                end else begin
                    want = resp_q.pop_front();
                    if (got.drive !== want.drive || got.read_value !== want.read_value ||
                        got.address_error !== want.address_error ||
                        got.power_status !== want.power_status ||
                        got.sync_seen !== want.sync_seen) begin
                        if (n_err < REPORT_MAX) begin
                            $write("response %0d mismatch (exp/got): drive %0d/%0d ",
                                   n_resp, want.drive, got.drive);
                            $display("read %02h/%02h err %b/%b power %b/%b sync %b/%b",
                                     want.read_value, got.read_value,
                                     want.address_error, got.address_error,
                                     want.power_status, got.power_status,
                                     want.sync_seen, got.sync_seen);
                        end
                        n_err++;
                    end
                end
                n_resp++;
            end
            if (s_tvalid && s_tready) begin
                sx_step(s_tuser, s_tdata[0], s_tdata[8:1], s_tdata[16:9], s_tdata[17], want);
                // directed rows with a hand-written answer override the prediction
                if (n_acc < DIR_ROWS && dir_tab[n_acc].typed) want = dir_tab[n_acc].want;
                resp_q.push_back(want);
                n_acc++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    function automatic dir_row_t row(logic [2:0] cmd, logic b, logic [7:0] a, logic [7:0] wv,
                                     logic pv, bit typed, result_t want);
        dir_row_t r;
        r.cmd   = cmd;
        r.b     = b;
        r.a     = a;
        r.wv    = wv;
        r.pv    = pv;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    // offer one request and hold it until taken; idle at random outside the steady stretch
    task automatic put_req(input logic [2:0] cmd, input logic b, input logic [7:0] a,
                           input logic [7:0] wv, input logic pv);
        while (!(n_sent >= STEADY_FROM && n_sent < STEADY_TO) &&
               $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'b0, pv, wv, a, b};
        do @(posedge aclk); while (!s_tready);
        n_sent++;
    endtask

    // drop valid and wait out every outstanding response
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (resp_q.size() != 0);
    endtask

    // a valid address whose entry belongs to frame fn
    function automatic logic [7:0] frame_addr(logic [3:0] fn);
        return {1'b0, 3'($urandom_range(FRAME_BYTES - 1)), 4'(LAST_FRAME - int'(fn))};
    endfunction

    task automatic host_cmd(input logic [3:0] fn);
        int         sel;
        logic [7:0] a;
        sel = $urandom_range(99);
        if (sel < 35) begin
            a = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                         : 8'($urandom_range(ADDRESS_COUNT - 1));
            put_req(CMD_READ, 1'($urandom_range(1)), a, 8'($urandom_range(255)),
                    1'($urandom_range(1)));
        end else if (sel < 70) begin
            sel = $urandom_range(99);
            if (sel < 70) a = frame_addr(fn);
            else if (sel < 85) a = 8'($urandom_range(ADDRESS_COUNT - 1));
            else a = 8'($urandom_range(255));
            put_req(CMD_WRITE, 1'($urandom_range(1)), a, 8'($urandom_range(255)),
                    1'($urandom_range(1)));
        end else if (sel < 85) begin
            put_req(CMD_POWER, 1'($urandom_range(1)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), 1'($urandom_range(1)));
        end else begin
            put_req(CMD_SYNC_QUERY, 1'($urandom_range(1)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), 1'($urandom_range(1)));
        end
    endtask

    // one bus bit, with now and then a host command slipped in ahead of it
    task automatic bus_bit(input logic b, input logic [3:0] fn);
        if ($urandom_range(9) == 0) host_cmd(fn);
        put_req(CMD_TICK, b, 8'($urandom_range(255)), 8'($urandom_range(255)),
                1'($urandom_range(1)));
    endtask

    // well-formed telegram: sync, power bit, frame number, seven data bytes;
    // separators are ones so that zero runs only occur in the sync preamble
    task automatic send_telegram(input logic [3:0] fn);
        logic [3:0] fsr;
        fsr = fn;
        repeat ($urandom_range(3))
            put_req(CMD_WRITE, 1'($urandom_range(1)), frame_addr(fn), 8'($urandom_range(255)),
                    1'($urandom_range(1)));
        repeat (SYNC_ZEROS + $urandom_range(3)) bus_bit(1'b0, fn);
        bus_bit(1'b1, fn);
        bus_bit(1'($urandom_range(1)), fn);
        bus_bit(1'b1, fn);
        for (int k = 0; k < FRAME_TICKS; k++) begin
            if (k % SEP_LEN == SEP_LEN - 1) begin
                bus_bit(1'b1, fn);
            end else begin
                bus_bit(fsr[3], fn);
                fsr = fsr << 1;
            end
        end
        for (int j = 0; j < FRAME_BYTES * BYTE_TICKS; j++)
            bus_bit((j % SEP_LEN == SEP_LEN - 1) ? 1'b1 : 1'($urandom_range(1)), fn);
    endtask

    // unstructured requests: any code, any field, breaks telegrams apart
    task automatic noise_burst();
        repeat ($urandom_range(24, 8))
            put_req(3'($urandom_range(CMD_SPARE_LAST)), 1'($urandom_range(1)),
                    8'($urandom_range(255)), 8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    initial begin : stimulus
        bit paused;
        paused = 1'b0;
        sx_reset();

        // address extremes, error codes and spare codes, with hand-written answers;
        // the sync sequence exercises an early one, extra zeros and a power request
        dir_tab[0]  = row(CMD_READ, 1'b0, 8'd0, 8'h00, 1'b0, 1'b1, NO_EFFECT);
        dir_tab[1]  = row(CMD_READ, 1'b1, 8'd255, 8'hFF, 1'b1, 1'b1, ADDR_FAULT);
        dir_tab[2]  = row(CMD_READ, 1'b0, 8'd112, 8'h00, 1'b0, 1'b1, ADDR_FAULT);
        dir_tab[3]  = row(CMD_WRITE, 1'b0, 8'd112, 8'hAA, 1'b0, 1'b1, ADDR_FAULT);
        dir_tab[4]  = row(CMD_SYNC_QUERY, 1'b0, 8'd0, 8'h00, 1'b0, 1'b1, NO_EFFECT);
        dir_tab[5]  = row(CMD_SPARE_FIRST, 1'b1, 8'd255, 8'hFF, 1'b1, 1'b1, NO_EFFECT);
        dir_tab[6]  = row(3'(CMD_SPARE_FIRST + 3'd1), 1'b0, 8'd0, 8'h00, 1'b0, 1'b1, NO_EFFECT);
        dir_tab[7]  = row(CMD_SPARE_LAST, 1'b1, 8'd111, 8'h55, 1'b1, 1'b1, NO_EFFECT);
        dir_tab[8]  = row(CMD_WRITE, 1'b0, 8'd0, 8'hFF, 1'b0, 1'b0, NO_EFFECT);
        dir_tab[9]  = row(CMD_WRITE, 1'b1, 8'd111, 8'h00, 1'b1, 1'b0, NO_EFFECT);
        dir_tab[10] = row(CMD_READ, 1'b0, 8'd0, 8'h00, 1'b0, 1'b0, NO_EFFECT);
        dir_tab[11] = row(CMD_READ, 1'b0, 8'd111, 8'h00, 1'b0, 1'b0, NO_EFFECT);
        dir_tab[12] = row(CMD_POWER, 1'b0, 8'd0, 8'h00, 1'b1, 1'b0, NO_EFFECT);
        dir_tab[13] = row(CMD_TICK, 1'b0, 8'd0, 8'h00, 1'b0, 1'b0, NO_EFFECT);
        dir_tab[14] = row(CMD_TICK, 1'b1, 8'd0, 8'h00, 1'b0, 1'b0, NO_EFFECT);
        dir_tab[15] = row(CMD_TICK, 1'b0, 8'd0, 8'h00, 1'b0, 1'b0, NO_EFFECT);
        dir_tab[16] = row(CMD_TICK, 1'b0, 8'd0, 8'h00, 1'b0, 1'b0, NO_EFFECT);
        dir_tab[17] = row(CMD_TICK, 1'b0, 8'd0, 8'h00, 1'b0, 1'b0, NO_EFFECT);
        dir_tab[18] = row(CMD_TICK, 1'b0, 8'd0, 8'h00, 1'b0, 1'b0, NO_EFFECT);
        dir_tab[19] = row(CMD_TICK, 1'b1, 8'd0, 8'h00, 1'b0, 1'b0, NO_EFFECT);
        dir_tab[20] = row(CMD_TICK, 1'b0, 8'd0, 8'h00, 1'b0, 1'b0, NO_EFFECT);
        dir_tab[21] = row(CMD_TICK, 1'b1, 8'd0, 8'h00, 1'b0, 1'b0, NO_EFFECT);
        dir_tab[22] = row(CMD_SYNC_QUERY, 1'b1, 8'd255, 8'hFF, 1'b1, 1'b0, NO_EFFECT);

        // hold reset once at the start, then release it
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++)
            put_req(dir_tab[i].cmd, dir_tab[i].b, dir_tab[i].a, dir_tab[i].wv, dir_tab[i].pv);
        drain();

        // mostly whole telegrams, frame 0 favored so the sync flag gets set often
        while (n_sent < ITEM_TARGET) begin
            if (!paused && n_sent >= PAUSE_AT) begin
                paused = 1'b1;
                drain();
            end
            if ($urandom_range(9) == 0) noise_burst();
            else send_telegram(($urandom_range(3) == 0) ? 4'd0 : 4'($urandom_range(LAST_FRAME)));
        end

        drain();
        repeat (DRAIN_TAIL) @(posedge aclk);
        if (n_err == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Response side: random backpressure, one long hold, one steady stretch
    // ------------------------------------------------------------------

    initial begin : sink
        bit held;
        held = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held && n_sent >= HOLD_AT) begin
                // hold off long enough for the block to back up into its input
                held = 1'b1;
                repeat (HOLD_CYCLES) begin
                    m_tready <= 1'b0;
                    @(posedge aclk);
                end
            end else begin
                if (n_sent >= STEADY_FROM && n_sent < STEADY_TO) m_tready <= 1'b1;
                else m_tready <= ($urandom_range(99) >= IDLE_PCT);
                @(posedge aclk);
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

endmodule

>>> files.f
rtl/sxbt_pkg.sv
rtl/sxbt_mirror.sv
rtl/sxbt_engine.sv
rtl/selectrix_bus_frame_transceiver.sv
tb/tb.sv
